[rtl/core/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse unit
// Element format, intermediate widths, cofactor index table and the
// payload carried along the divider chain.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int EW     = 32;           // element width
  localparam int FB     = 24;           // fraction bits
  localparam int NEL    = 9;            // elements per matrix
  localparam int PW     = 2 * EW;       // product width
  localparam int CW     = PW + 1;       // cofactor width, signed
  localparam int CHW    = CW - EW;      // upper cofactor slice width
  localparam int DPW    = EW + CHW;     // det partial product width
  localparam int DW     = 3 * EW;       // determinant magnitude width
  localparam int DETW   = DW + 1;       // signed determinant width
  localparam int QW     = EW + 1;       // quotient bits resolved by the chain
  localparam int NSH    = 2 * FB - QW;  // pre-shift of |cofactor| into remainder
  localparam int LIMW   = 48;           // limit register width
  localparam int LIMSH  = 3 * FB - LIMW;// limit alignment to det fraction bits
  localparam int IDX_W  = 4;

  localparam logic [QW-1:0] MAXV_POS = QW'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic [QW-1:0] MAXV_NEG = QW'(64'd1 << (EW - 1));
  localparam logic [EW-1:0] ONE_VAL  = (FB <= EW - 2) ? EW'(64'd1 << FB)
                                                      : EW'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic [LIMW-1:0] LIMIT_RST = LIMW'(28147);

  // cofactor i = a[k0]*a[k1] - a[k2]*a[k3]
  function automatic logic [IDX_W-1:0] cof_idx(input int i, input int j);
    logic [IDX_W-1:0] t [NEL][4];
    t[0] = '{4'd4, 4'd8, 4'd7, 4'd5};
    t[1] = '{4'd2, 4'd7, 4'd1, 4'd8};
    t[2] = '{4'd1, 4'd5, 4'd2, 4'd4};
    t[3] = '{4'd5, 4'd6, 4'd3, 4'd8};
    t[4] = '{4'd0, 4'd8, 4'd2, 4'd6};
    t[5] = '{4'd3, 4'd2, 4'd0, 4'd5};
    t[6] = '{4'd3, 4'd7, 4'd6, 4'd4};
    t[7] = '{4'd6, 4'd1, 4'd0, 4'd7};
    t[8] = '{4'd0, 4'd4, 4'd3, 4'd1};
    return t[i][j];
  endfunction

  typedef struct packed {
    logic                     sing;
    logic [DW-1:0]            dmag;
    logic [NEL-1:0]           neg;
    logic [NEL-1:0]           big;
    logic [NEL-1:0][DW-1:0]   rem;
    logic [NEL-1:0][QW-1:0]   quo;
  } div_t;

endpackage

[rtl/core/mi3_front.sv]
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Five register stages: products, cofactors, determinant partial products,
// determinant, divider setup (magnitudes, sign, singular and overflow test).
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [mi3_pkg::NEL*mi3_pkg::EW-1:0] data_i,
  input  logic [mi3_pkg::LIMW-1:0]        limit_i,
  output logic                            valid_o,
  output mi3_pkg::div_t                   div_o
);

  localparam int EW = mi3_pkg::EW;
  localparam int NEL = mi3_pkg::NEL;

  logic signed [EW-1:0]           a   [NEL];
  logic [4:0]                     vld_q;

  logic signed [mi3_pkg::PW-1:0]  p_q [NEL][2];
  logic signed [EW-1:0]           a1_q [3];
  logic signed [mi3_pkg::CW-1:0]  cof2_q [NEL];
  logic signed [EW-1:0]           a2_q [3];
  logic signed [mi3_pkg::CW-1:0]  cof3_q [NEL];
  logic signed [mi3_pkg::DPW-1:0] lo_q [3];
  logic signed [mi3_pkg::DPW-1:0] hi_q [3];
  logic signed [mi3_pkg::CW-1:0]  cof4_q [NEL];
  logic signed [mi3_pkg::DETW-1:0] det_q;
  logic signed [mi3_pkg::DETW-1:0] det_d;
  mi3_pkg::div_t                  div_d, div_q;

  for (genvar g = 0; g < NEL; g++) begin : g_unpack
    assign a[g] = data_i[g*EW +: EW];
  end

  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (mi3_pkg::DETW'(hi_q[k]) <<< EW) + mi3_pkg::DETW'(lo_q[k]);
    end
  end

  // divider setup: remainder starts at |cof| * 2^(2*FB) / 2^QW
  always_comb begin
    logic [mi3_pkg::PW-1:0]   cmag;
    logic [mi3_pkg::DETW-1:0] dabs;
    dabs = det_q[mi3_pkg::DETW-1] ? mi3_pkg::DETW'(-det_q) : det_q;
    div_d.dmag = dabs[mi3_pkg::DW-1:0];
    div_d.sing = (div_d.dmag == '0) ||
                 (div_d.dmag < (mi3_pkg::DW'(limit_i) << mi3_pkg::LIMSH));
    for (int i = 0; i < NEL; i++) begin
      cmag = cof4_q[i][mi3_pkg::CW-1] ? mi3_pkg::PW'(-cof4_q[i])
                                      : mi3_pkg::PW'(cof4_q[i]);
      div_d.rem[i] = mi3_pkg::DW'(cmag) << mi3_pkg::NSH;
      div_d.big[i] = div_d.rem[i] >= div_d.dmag;
      div_d.neg[i] = cof4_q[i][mi3_pkg::CW-1] ^ det_q[mi3_pkg::DETW-1];
      div_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NEL; i++) begin
        p_q[i][0] <= a[mi3_pkg::cof_idx(i, 0)] * a[mi3_pkg::cof_idx(i, 1)];
        p_q[i][1] <= a[mi3_pkg::cof_idx(i, 2)] * a[mi3_pkg::cof_idx(i, 3)];
        cof2_q[i] <= mi3_pkg::CW'(p_q[i][0]) - mi3_pkg::CW'(p_q[i][1]);
        cof3_q[i] <= cof2_q[i];
        cof4_q[i] <= cof3_q[i];
      end
      for (int k = 0; k < 3; k++) begin
        a1_q[k] <= a[k];
        a2_q[k] <= a1_q[k];
        lo_q[k] <= a2_q[k] * $signed({1'b0, cof2_q[3*k][EW-1:0]});
        hi_q[k] <= a2_q[k] * $signed(cof2_q[3*k][mi3_pkg::CW-1:EW]);
      end
      det_q <= det_d;
      div_q <= div_d;
    end
  end

  assign valid_o = vld_q[4];
  assign div_o   = div_q;

endmodule

[rtl/core/mi3_div_cell.sv]
// ----------------------------------------------------------------------------
// mi3_div_cell: one restoring division step for all nine lanes
// Resolve one quotient bit per lane and hand the remainder to the next cell.
// ----------------------------------------------------------------------------
module mi3_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  mi3_pkg::div_t div_i,
  output logic          valid_o,
  output mi3_pkg::div_t div_o
);

  logic          valid_q;
  mi3_pkg::div_t div_d, div_q;

  always_comb begin
    logic [mi3_pkg::DW:0] t;
    logic                 b;
    div_d = div_i;
    for (int i = 0; i < mi3_pkg::NEL; i++) begin
      t = {div_i.rem[i], 1'b0};
      b = t >= {1'b0, div_i.dmag};
      if (b) begin
        t = t - {1'b0, div_i.dmag};
      end
      div_d.rem[i] = t[mi3_pkg::DW-1:0];
      div_d.quo[i] = {div_i.quo[i][mi3_pkg::QW-2:0], b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

[rtl/core/matrix3_inverse_unit.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_unit: 3x3 matrix inverse by the adjugate, Q8.24
// Pipeline: 5 cofactor/determinant stages, a chain of 33 divider
// cells (one quotient bit each), one output register.
// Throughput one matrix per cycle; the whole pipeline holds while a result
// waits on m_axis_tready_i. Reset empties the pipeline and loads the
// singular limit with 28147 (about 1e-10).
// ----------------------------------------------------------------------------
module matrix3_inverse_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write: singular limit in units of 2^-48
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mi3_pkg::LIMW-1:0]              cfg_data_i,
  // input matrix
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
  input  logic [mi3_pkg::NEL*mi3_pkg::EW-1:0]   s_axis_tdata_i,
  // inverse
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
  output logic [mi3_pkg::NEL*mi3_pkg::EW-1:0]   m_axis_tdata_o,
  // singular, saturated
  output logic [1:0]                            m_axis_tuser_o
);

  localparam int NC = mi3_pkg::QW;
  localparam int EW = mi3_pkg::EW;

  logic [mi3_pkg::LIMW-1:0]               limit_q;
  logic                                   en;
  logic                                   vld [NC+1];
  mi3_pkg::div_t                          dv  [NC+1];
  logic                                   out_vld_q;
  logic [mi3_pkg::NEL*EW-1:0]             out_data_q, out_data_d;
  logic [1:0]                             out_user_q, out_user_d;

  // the whole pipeline advances unless a result sits unclaimed
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mi3_pkg::LIMIT_RST;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .limit_i (limit_q),
    .valid_o (vld[0]),
    .div_o   (dv[0])
  );

  // divider chain: cell c resolves quotient bit NC-1-c of every lane
  for (genvar c = 0; c < NC; c++) begin : g_cell
    mi3_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[c]),
      .div_i   (dv[c]),
      .valid_o (vld[c+1]),
      .div_o   (dv[c+1])
    );
  end

  // saturate, negate, or substitute the identity for a singular matrix
  always_comb begin
    logic [mi3_pkg::QW-1:0] q;
    logic                   sat;
    logic                   clip;
    sat = 1'b0;
    for (int i = 0; i < mi3_pkg::NEL; i++) begin
      q = dv[NC].quo[i];
      if (dv[NC].neg[i]) begin
        clip = dv[NC].big[i] || (q > mi3_pkg::MAXV_NEG);
        if (clip) begin
          q = mi3_pkg::MAXV_NEG;
        end
        q = -q;
      end else begin
        clip = dv[NC].big[i] || (q > mi3_pkg::MAXV_POS);
        if (clip) begin
          q = mi3_pkg::MAXV_POS;
        end
      end
      sat = sat | clip;
      if (dv[NC].sing) begin
        out_data_d[i*EW +: EW] = (i % 4 == 0) ? mi3_pkg::ONE_VAL : '0;
      end else begin
        out_data_d[i*EW +: EW] = q[EW-1:0];
      end
    end
    out_user_d = {sat & !dv[NC].sing, dv[NC].sing};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

[tb/sv/inverse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_checker: watches the matrix inverse unit and checks every result
// Tracks the singular limit from configuration transactions, computes the
// exact adjugate inverse of each accepted matrix and compares it field by
// field with the results that leave the block, in order.
// ----------------------------------------------------------------------------
module inverse_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [mi3_pkg::LIMW-1:0]             cfg_data_i,
  input  logic                                 s_valid_i,
  input  logic                                 s_ready_i,
  input  logic [mi3_pkg::NEL*mi3_pkg::EW-1:0]  s_data_i,
  input  logic                                 m_valid_i,
  input  logic                                 m_ready_i,
  input  logic [mi3_pkg::NEL*mi3_pkg::EW-1:0]  m_data_i,
  input  logic [1:0]                           m_user_i,
  output int                                   errors_o,
  output int                                   pending_o
);
  import mi3_pkg::*;

  typedef struct {
    logic [EW-1:0] elem [NEL];
    logic          sing;
    logic          sat;
  } inverse_t;

  logic [LIMW-1:0] sing_limit;
  inverse_t        inverse_q [$];
  int              err_cnt;

  // minor pairs per cofactor: a[p]*a[q] - a[r]*a[s]
  function automatic int minor_pos(input int i, input int j);
    int tab [NEL][4];
    tab = '{'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
            '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
            '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};
    return tab[i][j];
  endfunction

  function automatic inverse_t invert_matrix(input logic [NEL*EW-1:0] mat,
                                             input logic [LIMW-1:0] lim);
    logic signed [EW-1:0]  e;
    logic signed [127:0]   a [NEL];
    logic signed [127:0]   cof [NEL];
    logic signed [127:0]   det;
    logic [127:0]          dmag, cmag, quo, maxv;
    logic                  neg;
    inverse_t              r;
    maxv = (128'd1 << (EW - 1)) - 1;
    for (int i = 0; i < NEL; i++) begin
      e = mat[EW*i +: EW];
      a[i] = e;
    end
    for (int i = 0; i < NEL; i++)
      cof[i] = a[minor_pos(i, 0)] * a[minor_pos(i, 1)] - a[minor_pos(i, 2)] * a[minor_pos(i, 3)];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    dmag = det[127] ? -det : det;
    // |det| * 2^48 < limit * 2^72 reduces to |det| < limit * 2^24
    r.sing = (det == 0) || (dmag < (128'(lim) << (3 * FB - LIMW)));
    r.sat = 1'b0;
    for (int i = 0; i < NEL; i++) begin
      if (r.sing) begin
        r.elem[i] = (i % 4 == 0) ? EW'(128'd1 << FB) : '0;
      end else begin
        neg = cof[i][127] ^ det[127];
        cmag = cof[i][127] ? -cof[i] : cof[i];
        quo = (cmag << (2 * FB)) / dmag;
        if (!neg) begin
          if (quo > maxv) begin
            quo = maxv;
            r.sat = 1'b1;
          end
          r.elem[i] = quo[EW-1:0];
        end else begin
          if (quo > maxv + 1) begin
            quo = maxv + 1;
            r.sat = 1'b1;
          end
          r.elem[i] = EW'(-quo);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    logic [EW-1:0] got;
    if (!rst_ni) begin
      sing_limit <= 48'd28147;
      inverse_q.delete();
      err_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) sing_limit <= cfg_data_i;
      if (s_valid_i && s_ready_i) inverse_q.push_back(invert_matrix(s_data_i, sing_limit));
      if (m_valid_i && m_ready_i) begin
        if (inverse_q.size() == 0) begin
          $error("result transaction with no matrix outstanding");
          err_cnt++;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < NEL; i++) begin
            got = m_data_i[EW*i +: EW];
            if (got !== want.elem[i]) begin
              $error("out_r%0dc%0d: expected %h, actual %h", i / 3, i % 3, want.elem[i], got);
              err_cnt++;
            end
          end
          if (m_user_i[0] !== want.sing) begin
            $error("singular: expected %b, actual %b", want.sing, m_user_i[0]);
            err_cnt++;
          end
          if (m_user_i[1] !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, m_user_i[1]);
            err_cnt++;
          end
        end
      end
      errors_o <= err_cnt;
      pending_o <= inverse_q.size();
    end
  end
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the 3x3 matrix inverse unit
// Writes several singular limits, sends directed and random matrices under
// varying idle patterns and back pressure, and reports from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import mi3_pkg::*;

  localparam int LATENCY   = 45;    // block latency plus margin
  localparam int HOLD_LEN  = 300;   // long receiver hold-off
  localparam int WDOG_MAX  = 5000;  // cycles with no transaction at all

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LIMW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [NEL*EW-1:0]   s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [NEL*EW-1:0]   m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  int errors, pending;
  int send_idle_pct, recv_idle_pct;
  int hold_req, hold_done;
  int quiet_cycles;

  always #10 clk_i = ~clk_i;

  matrix3_inverse_unit dut (.*);

  inverse_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o), .s_data_i(s_axis_tdata_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_i(m_axis_tdata_o),
    .m_user_i(m_axis_tuser_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random ready, plus a long hold-off on request, counted here.
  initial begin
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_done = hold_req;
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long after reset.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one matrix; hold it until the transaction completes.
  task automatic send_matrix(input logic [NEL*EW-1:0] mat);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= mat;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drain every outstanding result, then let the pipeline settle.
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMW-1:0] lim);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [NEL*EW-1:0] diag_matrix(input logic [EW-1:0] d0,
                                                    input logic [EW-1:0] d1,
                                                    input logic [EW-1:0] d2);
    logic [NEL*EW-1:0] m;
    m = '0;
    m[0 +: EW] = d0;
    m[4*EW +: EW] = d1;
    m[8*EW +: EW] = d2;
    return m;
  endfunction

  function automatic logic [NEL*EW-1:0] fill_matrix(input logic [EW-1:0] v);
    logic [NEL*EW-1:0] m;
    for (int i = 0; i < NEL; i++) m[EW*i +: EW] = v;
    return m;
  endfunction

  // Random matrix: full range, moderate, near diagonal, or nearly singular.
  function automatic logic [NEL*EW-1:0] random_matrix;
    logic [NEL*EW-1:0] m;
    int kind, span;
    kind = $urandom_range(9);
    span = 1 << $urandom_range(30, 8);
    for (int i = 0; i < NEL; i++) begin
      case (kind)
        0, 1:    m[EW*i +: EW] = $urandom;
        2, 3, 4: m[EW*i +: EW] = EW'($urandom_range(2 * span - 1)) - EW'(span);
        5, 6, 7: m[EW*i +: EW] = ((i % 4 == 0) ? EW'($urandom_range(1 << 26)) : '0)
                                 + EW'($urandom_range(1 << 22)) - EW'(1 << 21);
        default: m[EW*i +: EW] = EW'($urandom_range(63)) - EW'(32);
      endcase
    end
    // make row 2 a copy of row 0 now and then: exactly singular
    if ($urandom_range(19) == 0) m[6*EW +: 3*EW] = m[0 +: 3*EW];
    return m;
  endfunction

  initial begin
    logic [LIMW-1:0] lim;
    hold_req = 0;
    send_idle_pct = 35;
    recv_idle_pct = 84;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: default limit, directed corners, then random.
    write_limit(48'd28147);
    send_matrix(diag_matrix(32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
    send_matrix(diag_matrix(32'h0200_0000, 32'hFF00_0000, 32'h0080_0000));
    send_matrix('0);
    send_matrix(fill_matrix(32'h7FFF_FFFF));
    send_matrix(fill_matrix(32'h8000_0000));
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag_matrix(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
    send_matrix(diag_matrix(32'h0000_4000, 32'h0000_4000, 32'h0000_4000));
    send_matrix(diag_matrix(32'h0080_0000, 32'h0080_0000, 32'hFF80_0000));
    send_matrix(diag_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_matrix({32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0,
                 32'h0, 32'h0, 32'h0000_0002});
    send_matrix({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom});
    // long receiver hold-off while matrices keep coming
    hold_req++;
    repeat (80) send_matrix(random_matrix());
    repeat (500) send_matrix(random_matrix());

    // Phase 2: limit zero (only an exact zero determinant is singular).
    send_idle_pct = 84;
    recv_idle_pct = 35;
    write_limit('0);
    send_matrix('0);
    send_matrix(fill_matrix(32'h0000_0001));
    send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    repeat (550) send_matrix(random_matrix());

    // Largest limit: every determinant below about one is singular.
    write_limit({LIMW{1'b1}});
    send_matrix(fill_matrix(32'h7FFF_FFFF));
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    repeat (40) send_matrix(random_matrix());

    // Phase 3: no idling, random limits.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 4; k++) begin
      lim = LIMW'({$urandom, $urandom} >> $urandom_range(47));
      write_limit(lim);
      repeat (160) send_matrix(random_matrix());
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[matrix3_inverse_unit.f]
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_div_cell.sv
rtl/core/matrix3_inverse_unit.sv
tb/sv/inverse_checker.sv
tb/sv/tb_top.sv
